FILE: rtl/core/rdpd_pkg.sv
// shared constants, codes and helpers for the remote debug packet deframer
`timescale 1ns / 1ps

package rdpd_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 12;
    localparam int MAX_LEN_RESET        = 2042;

    localparam int PHASE_W = 3;
    localparam int EVENT_W = 4;

    // lexer phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ESC  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CS1  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CS2  = 3'd4;

    // result event codes
    localparam logic [EVENT_W-1:0] EV_FRAMING = 4'd0;
    localparam logic [EVENT_W-1:0] EV_PAYLOAD = 4'd1;
    localparam logic [EVENT_W-1:0] EV_GOOD    = 4'd2;
    localparam logic [EVENT_W-1:0] EV_BADSUM  = 4'd3;
    localparam logic [EVENT_W-1:0] EV_TOOLONG = 4'd4;
    localparam logic [EVENT_W-1:0] EV_ACK     = 4'd5;
    localparam logic [EVENT_W-1:0] EV_NAK     = 4'd6;
    localparam logic [EVENT_W-1:0] EV_INTR    = 4'd7;
    localparam logic [EVENT_W-1:0] EV_REJECT  = 4'd8;

    // protocol characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_INTR   = 8'h03;
    localparam logic [7:0] CH_ESCAPE = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (b inside {[8'h30:8'h39]})
        begin
            d.value = 4'(b - 8'h30);
        end
        else if (b inside {[8'h61:8'h66]})
        begin
            d.value = 4'(b - 8'h57);
        end
        else if (b inside {[8'h41:8'h46]})
        begin
            d.value = 4'(b - 8'h37);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

FILE: rtl/core/remote_debug_packet_deframer_unit.sv
// an accepted byte goes through the input register, then the result register, before its result is out
// throughput: one byte per cycle while out_stall does not hold the result; each byte's lexer
// step is combinational between the input register and the result register
// reset: asynchronous active low; lexer idle, sum, count and overflow cleared,
// length limit back to 2042, both pipeline registers empty
`timescale 1ns / 1ps

module remote_debug_packet_deframer_unit #(
    parameter int LENGTH_WIDTH = rdpd_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   rx_byte,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [LENGTH_WIDTH-1:0]      cfg_data,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rdpd_pkg::EVENT_W-1:0] event_res,
    output logic [7:0]                   payload_byte,
    output logic [LENGTH_WIDTH-1:0]      payload_length
);

    // input register
    logic                         in_valid_reg;
    logic [7:0]                   byte_reg;

    // result register
    logic                         out_valid_reg;
    logic [rdpd_pkg::EVENT_W-1:0] event_reg;
    logic [7:0]                   pbyte_reg;
    logic [LENGTH_WIDTH-1:0]      plen_reg;

    // lexer state
    logic [LENGTH_WIDTH-1:0]      max_len_reg;
    logic [rdpd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]                   sum_reg, sum_next;
    logic [3:0]                   high_nib_reg, high_nib_next;
    logic [LENGTH_WIDTH-1:0]      count_reg, count_next;
    logic                         ovf_reg, ovf_next;

    logic [rdpd_pkg::EVENT_W-1:0] event_next;
    logic [7:0]                   pbyte_next;

    logic                         out_adv;
    logic                         in_adv;
    logic [7:0]                   sum_add;
    logic [7:0]                   data_byte;
    rdpd_pkg::hex_digit_t         digit;

    assign out_adv   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_adv    = !in_valid_reg || out_adv;
    assign in_stall  = !in_adv;
    assign cfg_ready = 1'b1;

    assign sum_add   = sum_reg + byte_reg;
    assign data_byte = (phase_reg == rdpd_pkg::PH_ESC) ? (byte_reg ^ rdpd_pkg::ESC_XOR)
                                                       : byte_reg;
    assign digit     = rdpd_pkg::hex_decode(byte_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        high_nib_next = high_nib_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        event_next    = rdpd_pkg::EV_FRAMING;
        pbyte_next    = 8'd0;
        case (phase_reg)
            rdpd_pkg::PH_DATA, rdpd_pkg::PH_ESC:
            begin
                if (phase_reg == rdpd_pkg::PH_DATA && byte_reg == rdpd_pkg::CH_HASH)
                begin
                    // '#' closes the payload and stays out of the sum
                    phase_next = rdpd_pkg::PH_CS1;
                end
                else if (phase_reg == rdpd_pkg::PH_DATA && byte_reg == rdpd_pkg::CH_ESCAPE)
                begin
                    sum_next   = sum_add;
                    phase_next = rdpd_pkg::PH_ESC;
                end
                else
                begin
                    sum_next   = sum_add;
                    phase_next = rdpd_pkg::PH_DATA;
                    if (count_reg >= max_len_reg)
                    begin
                        ovf_next   = 1'b1;
                        event_next = rdpd_pkg::EV_TOOLONG;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        event_next = rdpd_pkg::EV_PAYLOAD;
                        pbyte_next = data_byte;
                    end
                end
            end
            rdpd_pkg::PH_CS1:
            begin
                if (!digit.ok)
                begin
                    event_next = rdpd_pkg::EV_REJECT;
                end
                else
                begin
                    high_nib_next = digit.value;
                    phase_next    = rdpd_pkg::PH_CS2;
                end
            end
            rdpd_pkg::PH_CS2:
            begin
                if (!digit.ok)
                begin
                    event_next = rdpd_pkg::EV_REJECT;
                end
                else
                begin
                    if (ovf_reg)
                    begin
                        event_next = rdpd_pkg::EV_TOOLONG;
                    end
                    else if ({high_nib_reg, digit.value} == sum_reg)
                    begin
                        event_next = rdpd_pkg::EV_GOOD;
                    end
                    else
                    begin
                        event_next = rdpd_pkg::EV_BADSUM;
                    end
                    phase_next = rdpd_pkg::PH_IDLE;
                end
            end
            default:
            begin
                // idle, and any stray phase code
                phase_next = rdpd_pkg::PH_IDLE;
                case (byte_reg)
                    rdpd_pkg::CH_DOLLAR:
                    begin
                        sum_next   = 8'd0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        phase_next = rdpd_pkg::PH_DATA;
                    end
                    rdpd_pkg::CH_PLUS:  event_next = rdpd_pkg::EV_ACK;
                    rdpd_pkg::CH_MINUS: event_next = rdpd_pkg::EV_NAK;
                    rdpd_pkg::CH_INTR:  event_next = rdpd_pkg::EV_INTR;
                    default:            event_next = rdpd_pkg::EV_REJECT;
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_len_reg   <= LENGTH_WIDTH'(rdpd_pkg::MAX_LEN_RESET);
            phase_reg     <= rdpd_pkg::PH_IDLE;
            sum_reg       <= 8'd0;
            high_nib_reg  <= 4'd0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= cfg_data;
            end
            if (in_adv)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                sum_reg       <= sum_next;
                high_nib_reg  <= high_nib_next;
                count_reg     <= count_next;
                ovf_reg       <= ovf_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_adv && in_valid)
        begin
            byte_reg <= rx_byte;
        end
        if (out_adv)
        begin
            event_reg <= event_next;
            pbyte_reg <= pbyte_next;
            plen_reg  <= count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = event_reg;
    assign payload_byte   = pbyte_reg;
    assign payload_length = plen_reg;

endmodule
